// ===== hw/rtl/jhuf_pkg.sv =====
// Shared types and constants for the JPEG Huffman table loader and decoder.
package jhuf_pkg;
    localparam int MAX_CODE_LEN      = 16;
    localparam int TABLES_PER_CLASS  = 4;
    localparam int SYMBOLS_PER_TABLE = 256;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNTS  = 2'd1,
        PH_SYMBOLS = 2'd2,
        PH_SKIP    = 2'd3
    } t_phase;

    typedef struct packed {
        logic seg_load;
        logic dec_load;
        logic scan_step;
        logic sym_read;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_status;
endpackage

// ===== hw/rtl/jhuf_ctrl.sv =====
// Controller state machine sequencing segment parsing and decode requests.
module jhuf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_req_type,
    input  jhuf_pkg::t_status i_status,
    output jhuf_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import jhuf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_READ = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req_type) begin
                        o_cmd.dec_load = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.seg_load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.sym_read = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

// ===== hw/rtl/jhuf_dp.sv =====
// Datapath: table parser, count and symbol stores, code search and extra-bit decode.
module jhuf_dp #(
    parameter int TABLES_PER_CLASS  = jhuf_pkg::TABLES_PER_CLASS,
    parameter int SYMBOLS_PER_TABLE = jhuf_pkg::SYMBOLS_PER_TABLE
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jhuf_pkg::t_cmd  i_cmd,
    output jhuf_pkg::t_status o_status,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic            i_table_class,
    input  logic [1:0]      i_table_id,
    input  logic [31:0]     i_bit_window,
    output logic            o_valid,
    output logic [7:0]      o_symbol,
    output logic [4:0]      o_code_length,
    output logic signed [15:0] o_value,
    output logic [4:0]      o_bits_used,
    output logic            o_no_match
);
    import jhuf_pkg::*;

    localparam int NT   = 2 * TABLES_PER_CLASS;
    localparam int TW   = (NT > 1) ? $clog2(NT) : 1;
    localparam int SW   = $clog2(SYMBOLS_PER_TABLE);
    localparam int CNTW = SW + 1;
    localparam int MEMD = NT * (1 << SW);

    // count store: 8-bit counts with per-entry valid bits
    logic [7:0] r_cnt   [NT][MAX_CODE_LEN];
    logic [MAX_CODE_LEN-1:0] r_cvalid [NT];
    logic [7:0] r_sym_mem [MEMD];

    t_phase        r_phase;
    logic [TW-1:0] r_tab;
    logic [4:0]    r_lidx;
    logic [CNTW-1:0] r_left;
    logic [SW-1:0] r_widx;

    // decode registers
    logic [TW-1:0] r_dtab;
    logic          r_dbad;
    logic [31:0]   r_win;
    logic [4:0]    r_L;
    logic [7:0]    r_c;
    logic [16:0]   r_cum;
    logic [11:0]   r_base;
    logic [4:0]    r_len;
    logic [12:0]   r_idx;
    logic          r_hit;
    logic [7:0]    r_sym;

    logic [3:0] hcls;
    logic [3:0] hid;
    logic       hdr_ok;
    logic [CNTW+1:0] sum_left;
    logic [TW-1:0]   dec_tab;
    assign hcls   = i_data_byte[7:4];
    assign hid    = i_data_byte[3:0];
    assign hdr_ok = (hcls <= 4'd1) && ({28'd0, hid} < TABLES_PER_CLASS);
    assign sum_left = {2'b00, r_left} + (CNTW+2)'(i_data_byte);
    assign dec_tab  = TW'(32'(i_table_class) * TABLES_PER_CLASS + 32'(i_table_id));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_tab   <= '0;
            r_lidx  <= '0;
            r_left  <= '0;
            r_widx  <= '0;
            for (int t = 0; t < NT; t++) r_cvalid[t] <= '0;
        end else if (i_cmd.seg_load) begin
            case (r_phase)
                PH_HEADER: begin
                    if (hdr_ok) begin
                        r_tab  <= TW'(32'(hcls[0]) * TABLES_PER_CLASS + 32'(hid));
                        r_cvalid[TW'(32'(hcls[0]) * TABLES_PER_CLASS + 32'(hid))] <= '0;
                        r_lidx <= '0;
                        r_left <= '0;
                        r_widx <= '0;
                        r_phase <= PH_COUNTS;
                    end else begin
                        r_phase <= PH_SKIP;
                    end
                end
                PH_COUNTS: begin
                    r_cnt[r_tab][r_lidx[3:0]]    <= i_data_byte;
                    r_cvalid[r_tab][r_lidx[3:0]] <= 1'b1;
                    if (sum_left > (CNTW+2)'(SYMBOLS_PER_TABLE))
                        r_left <= CNTW'(SYMBOLS_PER_TABLE);
                    else
                        r_left <= sum_left[CNTW-1:0];
                    r_lidx <= r_lidx + 5'd1;
                    if (r_lidx == 5'd15)
                        r_phase <= (sum_left != '0) ? PH_SYMBOLS : PH_HEADER;
                end
                PH_SYMBOLS: begin
                    r_widx <= r_widx + SW'(1);
                    if (r_left != '0) r_left <= r_left - CNTW'(1);
                    if (r_left <= CNTW'(1)) r_phase <= PH_HEADER;
                end
                default: ;
            endcase
            if (i_last_byte) r_phase <= PH_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_load && r_phase == PH_SYMBOLS)
            r_sym_mem[{r_tab, r_widx}] <= i_data_byte;
        if (i_cmd.sym_read)
            r_sym <= r_sym_mem[{r_dtab, r_idx[SW-1:0]}];
    end

    // code search: one length per cycle, count for the next length fetched ahead
    logic [23:0] span;
    logic [16:0] top;
    logic [16:0] diff;
    logic [3:0]  sh;
    logic        fits;
    assign sh   = 4'(5'd16 - r_L);
    assign span = {16'd0, r_c} << sh;
    assign top  = {1'b0, r_win[31:16]};
    assign diff = top - r_cum;
    assign fits = {7'd0, top} < ({7'd0, r_cum} + span);

    assign o_status.scan_done = r_hit || r_dbad || (r_L == 5'd16) || fits;

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec_load) begin
            r_dtab <= dec_tab;
            r_dbad <= (32'(i_table_id) >= TABLES_PER_CLASS);
            r_win  <= i_bit_window;
            r_L    <= 5'd1;
            r_c    <= r_cvalid[dec_tab][0] ? r_cnt[dec_tab][0] : 8'd0;
            r_cum  <= '0;
            r_base <= '0;
            r_len  <= '0;
            r_idx  <= '0;
            r_hit  <= 1'b0;
        end else if (i_cmd.scan_step && !r_hit && !r_dbad) begin
            if (fits) begin
                r_hit <= 1'b1;
                r_len <= r_L;
                r_idx <= 13'(r_base) + 13'(diff >> sh);
            end else begin
                r_cum  <= r_cum + span[16:0];
                r_base <= r_base + 12'(r_c);
                if (r_L != 5'd16) begin
                    r_L <= r_L + 5'd1;
                    r_c <= r_cvalid[r_dtab][r_L[3:0]] ? r_cnt[r_dtab][r_L[3:0]] : 8'd0;
                end
            end
        end
    end

    // extra bits
    logic [3:0]  s;
    logic [31:0] shw;
    logic [15:0] raw;
    logic [15:0] v;
    logic        nm;
    assign nm  = r_dbad || !r_hit || (32'(r_idx) >= SYMBOLS_PER_TABLE);
    assign s   = r_sym[3:0];
    assign shw = r_win << r_len;
    always_comb begin
        raw = (s == 4'd0) ? 16'd0 : 16'(shw >> (6'd32 - {2'd0, s}));
        v   = raw;
        if (s != 4'd0 && !raw[s - 4'd1])
            v = raw - (16'd1 << s) + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= i_cmd.finish;
        if (i_cmd.finish) begin
            o_no_match    <= nm;
            o_symbol      <= nm ? 8'd0 : r_sym;
            o_code_length <= nm ? 5'd0 : r_len;
            o_value       <= nm ? 16'sd0 : signed'(v);
            o_bits_used   <= nm ? 5'd0 : r_len + {1'b0, s};
        end
    end
endmodule

// ===== hw/rtl/jpeg_huffman_table_load_and_decode.sv =====
// Top level of the JPEG Huffman table loader and decoder.
// Usage: pulse start with the item fields while busy is low.
// i_req_type = 0 loads one table segment byte; it does not raise busy and
// gives no result. i_req_type = 1 is a decode request: the block scans
// code lengths one per cycle (up to the matched length in the count
// store, or to length 16), then reads the symbol store and forms the
// result, which appears on the o_ ports for one cycle with o_valid high.
// No new request is taken while a decode is in progress.
// busy stays high from acceptance of a decode until the result is shown.
// The receiver cannot stall; results are never held.
// After reset all tables are empty (every count zero) and the parser
// expects a header byte. Symbol store contents are undefined until
// loaded; no clearing pass is needed.
module jpeg_huffman_table_load_and_decode #(
    parameter int TABLES_PER_CLASS  = jhuf_pkg::TABLES_PER_CLASS,
    parameter int SYMBOLS_PER_TABLE = jhuf_pkg::SYMBOLS_PER_TABLE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_table_class,
    input  logic [1:0]  i_table_id,
    input  logic [31:0] i_bit_window,
    output logic        o_valid,
    output logic [7:0]  o_symbol,
    output logic [4:0]  o_code_length,
    output logic signed [15:0] o_value,
    output logic [4:0]  o_bits_used,
    output logic        o_no_match
);
    import jhuf_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctl_busy;

    jhuf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (ctl_busy)
    );

    assign busy = ctl_busy;

    jhuf_dp #(
        .TABLES_PER_CLASS  (TABLES_PER_CLASS),
        .SYMBOLS_PER_TABLE (SYMBOLS_PER_TABLE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_table_class (i_table_class),
        .i_table_id    (i_table_id),
        .i_bit_window  (i_bit_window),
        .o_valid       (o_valid),
        .o_symbol      (o_symbol),
        .o_code_length (o_code_length),
        .o_value       (o_value),
        .o_bits_used   (o_bits_used),
        .o_no_match    (o_no_match)
    );
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the JPEG Huffman table loader and decoder.
module tb_top;
    import jhuf_pkg::*;

    localparam int NTAB  = 2 * TABLES_PER_CLASS;
    localparam int LIMIT = 400000;
    localparam logic REQ_SEG = 1'b0;
    localparam logic REQ_DEC = 1'b1;

    typedef struct {
        logic [7:0]         symbol;
        logic [4:0]         code_length;
        logic signed [15:0] value;
        logic [4:0]         bits_used;
        logic               no_match;
        logic               unwritten;
    } t_huff_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        i_table_class;
    logic [1:0]  i_table_id;
    logic [31:0] i_bit_window;
    logic        o_valid;
    logic [7:0]  o_symbol;
    logic [4:0]  o_code_length;
    logic signed [15:0] o_value;
    logic [4:0]  o_bits_used;
    logic        o_no_match;

    jpeg_huffman_table_load_and_decode dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte), .i_table_class(i_table_class),
        .i_table_id(i_table_id), .i_bit_window(i_bit_window),
        .o_valid(o_valid), .o_symbol(o_symbol), .o_code_length(o_code_length),
        .o_value(o_value), .o_bits_used(o_bits_used), .o_no_match(o_no_match)
    );

    logic [7:0] code_counts [NTAB][MAX_CODE_LEN];
    logic [7:0] sym_mem     [NTAB][SYMBOLS_PER_TABLE];
    bit         sym_written [NTAB][SYMBOLS_PER_TABLE];
    t_phase     parse_ph;
    int         cur_tab;
    int         len_idx;
    int         syms_left;
    int         sym_wr_idx;

    t_huff_res  pending_syms[$];
    int         mismatches;
    int         cycle_cnt;
    int         burst_left;
    int         n_seg_bytes;
    int         n_decodes;
    int         n_nomatch;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int cls;
        int id;
        cls = b[7:4];
        id  = b[3:0];
        case (parse_ph)
            PH_HEADER: begin
                if (cls > 1 || id >= TABLES_PER_CLASS) begin
                    parse_ph = PH_SKIP;
                end else begin
                    cur_tab = cls * TABLES_PER_CLASS + id;
                    for (int l = 0; l < MAX_CODE_LEN; l++) code_counts[cur_tab][l] = 8'd0;
                    len_idx    = 0;
                    syms_left  = 0;
                    sym_wr_idx = 0;
                    parse_ph   = PH_COUNTS;
                end
            end
            PH_COUNTS: begin
                code_counts[cur_tab][len_idx % MAX_CODE_LEN] = b;
                syms_left += b;
                if (syms_left > SYMBOLS_PER_TABLE) syms_left = SYMBOLS_PER_TABLE;
                len_idx++;
                if (len_idx >= MAX_CODE_LEN) parse_ph = (syms_left != 0) ? PH_SYMBOLS : PH_HEADER;
            end
            PH_SYMBOLS: begin
                sym_mem[cur_tab][sym_wr_idx % SYMBOLS_PER_TABLE]     = b;
                sym_written[cur_tab][sym_wr_idx % SYMBOLS_PER_TABLE] = 1'b1;
                sym_wr_idx++;
                if (syms_left != 0) syms_left--;
                if (syms_left == 0) parse_ph = PH_HEADER;
            end
            default: ;
        endcase
        if (last) parse_ph = PH_HEADER;
    endtask

    function automatic t_huff_res decode_symbol(input logic cls, input logic [1:0] id,
                                                input logic [31:0] win);
        t_huff_res r;
        int unsigned top;
        int unsigned cum;
        int unsigned base;
        int unsigned idx;
        int unsigned span;
        int unsigned c;
        int          len;
        int          t;
        int          s;
        logic [31:0] shifted;
        logic [31:0] raw;
        logic [31:0] v;
        r = '{8'd0, 5'd0, 16'sd0, 5'd0, 1'b1, 1'b0};
        if (id >= TABLES_PER_CLASS) return r;
        t    = cls * TABLES_PER_CLASS + id;
        top  = win[31:16];
        cum  = 0;
        base = 0;
        idx  = 0;
        len  = 0;
        for (int l = 1; l <= MAX_CODE_LEN; l++) begin
            c    = code_counts[t][l-1];
            span = c << (MAX_CODE_LEN - l);
            if (top < cum + span) begin
                idx = base + ((top - cum) >> (MAX_CODE_LEN - l));
                len = l;
                break;
            end
            cum  += span;
            base += c;
        end
        if (len == 0 || idx >= SYMBOLS_PER_TABLE) return r;
        r.unwritten = !sym_written[t][idx];
        r.symbol    = sym_mem[t][idx];
        s           = r.symbol[3:0];
        v           = 32'd0;
        if (s != 0) begin
            shifted = win << len;
            raw     = shifted >> (32 - s);
            v       = raw;
            if (raw < (32'd1 << (s - 1))) v = raw - (32'd1 << s) + 32'd1;
        end
        r.code_length = len[4:0];
        r.value       = v[15:0];
        r.bits_used   = 5'(len + s);
        r.no_match    = 1'b0;
        return r;
    endfunction

    task automatic send_beat(input logic req, input logic [7:0] b, input logic last,
                             input logic cls, input logic [1:0] id, input logic [31:0] win);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start         <= 1'b1;
        i_req_type    <= req;
        i_data_byte   <= b;
        i_last_byte   <= last;
        i_table_class <= cls;
        i_table_id    <= id;
        i_bit_window  <= win;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if (req == REQ_SEG) begin
            parse_byte(b, last);
            n_seg_bytes++;
        end else begin
            pending_syms.push_back(decode_symbol(cls, id, win));
            n_decodes++;
        end
    endtask

    task automatic send_seg_byte(input logic [7:0] b, input logic last);
        send_beat(REQ_SEG, b, last, 1'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic send_decode(input logic cls, input logic [1:0] id, input logic [31:0] win);
        send_beat(REQ_DEC, 8'($urandom), 1'($urandom), cls, id, win);
    endtask

    // Pick a request that never reads a symbol entry left unwritten.
    task automatic send_random_decode();
        logic        cls;
        logic [1:0]  id;
        logic [31:0] win;
        t_huff_res   r;
        for (int tries = 0; tries < 100; tries++) begin
            cls = 1'($urandom);
            id  = 2'($urandom);
            win = $urandom;
            if ($urandom_range(0, 15) == 0) win[31:16] = 16'hFFFF;
            r = decode_symbol(cls, id, win);
            if (!r.unwritten) begin
                send_decode(cls, id, win);
                return;
            end
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_syms.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_huff_res e;
        if (i_rst_n && o_valid) begin
            if (pending_syms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat with nothing pending");
            end else begin
                e = pending_syms.pop_front();
                if (o_no_match) n_nomatch++;
                if (o_symbol !== e.symbol || o_code_length !== e.code_length ||
                    o_value !== e.value || o_bits_used !== e.bits_used ||
                    o_no_match !== e.no_match) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp sym %h len %0d val %0d used %0d nm %b, got sym %h len %0d val %0d used %0d nm %b",
                                 e.symbol, e.code_length, e.value, e.bits_used, e.no_match,
                                 o_symbol, o_code_length, o_value, o_bits_used, o_no_match);
                end
            end
        end
    end

    task automatic test_small_table();
        logic [7:0] cnts [MAX_CODE_LEN] = '{0, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
        logic [7:0] syms [6] = '{8'h00, 8'h0F, 8'h01, 8'h85, 8'h0B, 8'hFA};
        send_seg_byte(8'h00, 1'b0);
        foreach (cnts[i]) send_seg_byte(cnts[i], 1'b0);
        foreach (syms[i]) send_seg_byte(syms[i], i == 5);
        send_decode(1'b0, 2'd0, 32'h0000_0000);
        send_decode(1'b0, 2'd0, 32'h7FFF_FFFF);
        send_decode(1'b0, 2'd0, 32'h4000_0000);
        send_decode(1'b0, 2'd0, 32'h8000_0000);
        send_decode(1'b0, 2'd0, 32'hA000_0000);
        send_decode(1'b0, 2'd0, 32'hC000_0000);
        send_decode(1'b0, 2'd0, 32'hE000_0000);
        send_decode(1'b0, 2'd0, 32'hFFFF_FFFF);
        send_decode(1'b1, 2'd3, 32'h1234_5678);
    endtask

    task automatic test_bad_headers();
        send_seg_byte(8'h25, 1'b0);
        send_seg_byte(8'h03, 1'b0);
        send_seg_byte(8'h07, 1'b1);
        send_seg_byte(8'h04, 1'b0);
        send_seg_byte(8'hFF, 1'b1);
        send_decode(1'b0, 2'd0, 32'h8000_0000);
    endtask

    // Redefine the small table, cut short after three counts.
    task automatic test_short_segment();
        send_seg_byte(8'h00, 1'b0);
        send_seg_byte(8'h00, 1'b0);
        send_seg_byte(8'h02, 1'b0);
        send_seg_byte(8'h01, 1'b1);
        send_decode(1'b0, 2'd0, 32'h0000_0000);
        send_decode(1'b0, 2'd0, 32'h9000_0000);
        send_decode(1'b0, 2'd0, 32'hC000_0000);
    endtask

    task automatic test_symbol_saturation();
        send_seg_byte(8'h11, 1'b0);
        for (int l = 0; l < MAX_CODE_LEN; l++) send_seg_byte((l == 7 || l == 8) ? 8'd255 : 8'd0, 1'b0);
        for (int i = 0; i < SYMBOLS_PER_TABLE; i++) send_seg_byte(8'($urandom), 1'b0);
        send_seg_byte(8'h12, 1'b0);
        send_seg_byte(8'h01, 1'b1);
        send_decode(1'b1, 2'd1, 32'h0000_0000);
        send_decode(1'b1, 2'd1, 32'hFF00_FFFF);
        send_decode(1'b1, 2'd1, 32'hFF7F_0000);
        send_decode(1'b1, 2'd1, 32'hFF80_0000);
        send_decode(1'b1, 2'd1, 32'hFFFF_FFFF);
    endtask

    task automatic send_random_segment(input bit broken);
        int ntabs;
        int total;
        int cut;
        int n;
        logic [7:0] seg[$];
        ntabs = broken ? 1 : $urandom_range(1, 2);
        for (int k = 0; k < ntabs; k++) begin
            logic [7:0] cnts [MAX_CODE_LEN];
            total = 0;
            seg.push_back({3'd0, 1'($urandom), 2'd0, 2'($urandom)});
            foreach (cnts[l]) begin
                cnts[l] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 4)) : 8'd0;
                if ($urandom_range(0, 60) == 0) cnts[l] = 8'($urandom_range(20, 255));
            end
            if (cnts.sum() with (int'(item)) == 0) cnts[$urandom_range(0, 15)] = 8'd2;
            foreach (cnts[l]) begin
                seg.push_back(cnts[l]);
                total += cnts[l];
            end
            if (total > SYMBOLS_PER_TABLE) total = SYMBOLS_PER_TABLE;
            repeat (total) seg.push_back(8'($urandom));
        end
        n = seg.size();
        if (broken) begin
            cut = $urandom_range(1, n - 1);
            if ($urandom_range(0, 2) == 0) seg[0] = 8'($urandom_range(0, 255)) | 8'h20;
            n = cut;
        end
        for (int i = 0; i < n; i++) send_seg_byte(seg[i], i == n - 1);
    endtask

    task automatic test_random_traffic();
        int choice;
        bit drained;
        drained = 1'b0;
        while (n_seg_bytes + n_decodes < 600) begin
            choice = $urandom_range(0, 99);
            if (choice < 12) send_random_segment(1'b0);
            else if (choice < 16) send_random_segment(1'b1);
            else if (choice < 19) send_seg_byte(8'($urandom), 1'b1);
            else send_random_decode();
            if (!drained && n_seg_bytes + n_decodes >= 460) begin
                wait_drain();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = 1'b0;
        i_data_byte   = 8'd0;
        i_last_byte   = 1'b0;
        i_table_class = 1'b0;
        i_table_id    = 2'd0;
        i_bit_window  = 32'd0;
        cycle_cnt     = 0;
        mismatches    = 0;
        burst_left    = 0;
        n_seg_bytes   = 0;
        n_decodes     = 0;
        n_nomatch     = 0;
        for (int t = 0; t < NTAB; t++) begin
            for (int l = 0; l < MAX_CODE_LEN; l++) code_counts[t][l] = 8'd0;
            for (int s = 0; s < SYMBOLS_PER_TABLE; s++) begin
                sym_mem[t][s]     = 8'd0;
                sym_written[t][s] = 1'b0;
            end
        end
        parse_ph   = PH_HEADER;
        cur_tab    = 0;
        len_idx    = 0;
        syms_left  = 0;
        sym_wr_idx = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_table();
        test_bad_headers();
        test_short_segment();
        test_symbol_saturation();
        test_random_traffic();
        wait_drain();

        $display("covered %0d segment bytes and %0d decodes (%0d without a match)",
                 n_seg_bytes, n_decodes, n_nomatch);
        if (mismatches == 0 && pending_syms.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_syms.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
